// ===== rtl/sorted_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted list engine assertion macros
// Concurrent assertion wrappers for the sorted list engine. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_ENGINE_ASSERT_SVH
`define SORTED_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset.
`define SLE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted list engine: assertion failed");

// Checked on every rising edge, reset included.
`define SLE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sorted list engine: assertion failed");

`else

`define SLE_ASSERT(label, prop)
`define SLE_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== rtl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine package
// Operation codes, result status codes and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sle_pkg;

  // Operation codes carried by an input item.
  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_READ_ASC  = 3'd1,
    OP_READ_DESC = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_CLEAR     = 3'd4
  } opcode_t;

  // Status codes carried by a result item.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_READ,
    S_REMOVE,
    S_RESP
  } state_t;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REMOVED_W = 6;
  localparam int unsigned REMOVED_MAX = 63;

endpackage

// ===== rtl/sorted_list_engine.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine
// Bounded multiset of signed 32-bit values kept in ascending order in one
// synchronous memory, with insert, ordered read-out, remove-all and clear.
// ----------------------------------------------------------------------------
// The values live in a single memory of CAPACITY words with one write port
// and one registered read port, and the number of stored values is held in
// a register, so nothing needs clearing after reset. One item is worked on
// at a time; a new item is taken only when the controller is idle, while the
// previous result may still wait in the output register. A read in either
// direction issues one memory read per cycle while the output side keeps
// ready high, its first value passing through the memory read register and
// the output register. An insert walks down from the top entry, moving each
// value not smaller than the new one up one place; a remove compacts the
// whole store. Clear and every operation that finds the store empty or full
// go straight to the result, and an unused opcode is dropped without one. A
// waiting result holds the engine until the output side takes it. The single
// read port sets the pace of reads, inserts and removes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_list_engine_assert.svh"

module sorted_list_engine
  import sle_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   opcode,
  input  logic signed [DATA_W-1:0]     value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_W-1:0]     data,
  output logic [REMOVED_W-1:0]         removed_count,
  output logic [1:0]                   status,
  output logic                         last
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned GW = (CW > REMOVED_W) ? CW : REMOVED_W;

  // Control registers.
  state_t               state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        iss, iss_next;
  logic [CW-1:0]        em, em_next;
  logic                 pend, pend_next;
  logic                 desc, desc_next;

  // Item and response registers.
  logic [IW-1:0]             pend_idx, pend_idx_next;
  logic signed [DATA_W-1:0]  op_value, op_value_next;
  status_t                   resp_status, resp_status_next;
  logic [REMOVED_W-1:0]      resp_removed, resp_removed_next;

  // Memory ports.
  logic signed [DATA_W-1:0]  mem [CAPACITY];
  logic signed [DATA_W-1:0]  rdata;
  logic                      wr_en;
  logic [IW-1:0]             wr_addr;
  logic signed [DATA_W-1:0]  wr_data;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;

  // Output register loading.
  logic                      can_load;
  logic                      out_load;
  logic signed [DATA_W-1:0]  load_data;
  logic [REMOVED_W-1:0]      load_removed;
  status_t                   load_status;
  logic                      load_last;

  // Removal tally, saturated to the width of the result field.
  logic [CW-1:0]             gone;
  logic [GW-1:0]             gone_wide;
  logic [REMOVED_W-1:0]      gone_sat;
  logic                      ins_done;
  logic [CW-1:0]             desc_idx;

  assign gone      = count - em;
  assign gone_wide = GW'(gone);
  assign gone_sat  = (gone_wide > GW'(REMOVED_MAX)) ? REMOVED_W'(REMOVED_MAX)
                                                    : gone_wide[REMOVED_W-1:0];
  assign desc_idx  = count - 1'b1 - iss;
  assign can_load  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // Next state, memory accesses and result loading.
  always_comb begin
    state_next        = state;
    count_next        = count;
    iss_next          = iss;
    em_next           = em;
    pend_next         = pend;
    desc_next         = desc;
    pend_idx_next     = pend_idx;
    op_value_next     = op_value;
    resp_status_next  = resp_status;
    resp_removed_next = resp_removed;
    wr_en             = 1'b0;
    wr_addr           = '0;
    wr_data           = op_value;
    rd_en             = 1'b0;
    rd_addr           = '0;
    out_load          = 1'b0;
    load_data         = '0;
    load_removed      = '0;
    load_status       = ST_OK;
    load_last         = 1'b1;
    ins_done          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_value_next     = value;
          iss_next          = '0;
          em_next           = '0;
          pend_next         = 1'b0;
          resp_removed_next = '0;
          resp_status_next  = ST_OK;
          unique case (opcode) inside
            OP_INSERT: begin
              if (count == CW'(CAPACITY)) begin
                resp_status_next = ST_FULL;
                state_next       = S_RESP;
              end else begin
                iss_next   = count;
                state_next = S_INSERT;
              end
            end
            OP_READ_ASC, OP_READ_DESC: begin
              if (count == '0) begin
                resp_status_next = ST_EMPTY;
                state_next       = S_RESP;
              end else begin
                desc_next  = (opcode == OP_READ_DESC);
                state_next = S_READ;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                resp_status_next = ST_EMPTY;
                state_next       = S_RESP;
              end else begin
                state_next = S_REMOVE;
              end
            end
            OP_CLEAR: begin
              if (count == '0) begin
                resp_status_next = ST_EMPTY;
              end else begin
                count_next = '0;
              end
              state_next = S_RESP;
            end
            default: begin
              // Unused codes are taken and dropped without a result.
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_INSERT: begin
        // Walk downwards: a value not smaller than the new one moves up one
        // place; the first smaller one, or the bottom, marks the slot.
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = IW'(pend_idx + 1'b1);
          if (op_value <= rdata) begin
            wr_data = rdata;
          end else begin
            wr_data  = op_value;
            ins_done = 1'b1;
          end
        end else if (iss == '0) begin
          wr_en    = 1'b1;
          wr_addr  = '0;
          wr_data  = op_value;
          ins_done = 1'b1;
        end
        if (ins_done) begin
          count_next       = count + 1'b1;
          resp_status_next = ST_OK;
          pend_next        = 1'b0;
          state_next       = S_RESP;
        end else if (iss != '0) begin
          rd_en         = 1'b1;
          rd_addr       = IW'(iss - 1'b1);
          iss_next      = iss - 1'b1;
          pend_idx_next = IW'(iss - 1'b1);
          pend_next     = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end

      S_READ: begin
        // One read in flight; the next is issued when the output slot frees.
        if (pend && can_load) begin
          out_load  = 1'b1;
          load_data = rdata;
          load_last = (em == count - 1'b1);
          em_next   = em + 1'b1;
          if (load_last) begin
            state_next = S_IDLE;
          end
        end
        if ((iss != count) && (!pend || can_load)) begin
          rd_en     = 1'b1;
          rd_addr   = desc ? desc_idx[IW-1:0] : iss[IW-1:0];
          iss_next  = iss + 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next = pend && !can_load;
        end
      end

      S_REMOVE: begin
        // Compact the store: every value that differs is written at the
        // keep pointer, which never passes the read pointer.
        if (pend && (rdata != op_value)) begin
          wr_en   = 1'b1;
          wr_addr = em[IW-1:0];
          wr_data = rdata;
          em_next = em + 1'b1;
        end
        if (iss != count) begin
          rd_en     = 1'b1;
          rd_addr   = iss[IW-1:0];
          iss_next  = iss + 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (!pend && (iss == count)) begin
          count_next = em;
          if (gone == '0) begin
            resp_status_next  = ST_NOTFOUND;
            resp_removed_next = '0;
          end else begin
            resp_status_next  = ST_OK;
            resp_removed_next = gone_sat;
          end
          state_next = S_RESP;
        end
      end

      S_RESP: begin
        if (can_load) begin
          out_load     = 1'b1;
          load_status  = resp_status;
          load_removed = resp_removed;
          load_last    = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      iss       <= '0;
      em        <= '0;
      pend      <= 1'b0;
      desc      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      iss   <= iss_next;
      em    <= em_next;
      pend  <= pend_next;
      desc  <= desc_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item, response and output payload registers.
  always_ff @(posedge clk) begin
    pend_idx     <= pend_idx_next;
    op_value     <= op_value_next;
    resp_status  <= resp_status_next;
    resp_removed <= resp_removed_next;
    if (out_load) begin
      data          <= load_data;
      removed_count <= load_removed;
      status        <= load_status;
      last          <= load_last;
    end
  end

  // Value store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // The fill count never passes the capacity.
  `SLE_ASSERT(a_count_bound, count <= CW'(CAPACITY))
  // An insert only runs when there is room for one more value.
  `SLE_ASSERT(a_insert_room, (state == S_INSERT) |-> (count < CW'(CAPACITY)))
  // A read never issues beyond the stored values.
  `SLE_ASSERT(a_read_bound, (state == S_READ) |-> (iss <= count))
  // The keep pointer of a remove stays behind the read pointer.
  `SLE_ASSERT(a_keep_behind, (state == S_REMOVE) |-> (em <= iss))
  // A read ends only by handing over its final value.
  `SLE_ASSERT(a_read_ends_last,
              ((state == S_READ) && (state_next == S_IDLE)) |-> (out_load && load_last))

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine testbench
// Drives insert, ordered read, remove and clear items into the engine and
// checks every result against a behavioural copy of the sorted store. A
// directed part covers the empty and full store, the value extremes and the
// ignored opcodes. A random part follows under changing handshake idling. One
// long receiver hold-off lets the engine fill up and stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sle_pkg::*;

  localparam int unsigned CAPACITY = 32;

  // Opcodes that the engine must ignore without a result.
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // One result item as the engine should present it.
  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [REMOVED_W-1:0]     removed;
    status_t                  status;
    logic                     last;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] opcode = 3'd0;
  logic signed [DATA_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] data;
  logic [REMOVED_W-1:0] removed_count;
  logic [1:0] status;
  logic last;

  // Shadow copy of the sorted store.
  logic signed [DATA_W-1:0] shadow_vals [CAPACITY];
  int unsigned shadow_count = 0;
  list_result_t expected_results [$];

  // Handshake idling and the receiver hold-off request.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned full_rejects = 0;
  int unsigned multi_removes = 0;
  int unsigned max_read_len = 0;

  sorted_list_engine #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data         (data),
    .removed_count(removed_count),
    .status       (status),
    .last         (last)
  );

  always #2 clk = ~clk;

  // Work out the results of one accepted item and update the shadow store.
  function automatic void predict_results(input logic [2:0] op,
                                          input logic signed [DATA_W-1:0] val);
    list_result_t r;
    int unsigned pos;
    int unsigned kept;
    int unsigned gone;
    r.data    = '0;
    r.removed = '0;
    r.status  = ST_OK;
    r.last    = 1'b1;
    if (op > OP_CLEAR) return;
    if (op == OP_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
        full_rejects++;
      end else begin
        pos = 0;
        while (pos < shadow_count && val > shadow_vals[pos]) pos++;
        for (int unsigned i = shadow_count; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
        shadow_vals[pos] = val;
        shadow_count++;
      end
      expected_results.push_back(r);
      return;
    end
    if (shadow_count == 0) begin
      r.status = ST_EMPTY;
      expected_results.push_back(r);
      return;
    end
    case (op)
      OP_READ_ASC, OP_READ_DESC: begin
        for (int unsigned i = 0; i < shadow_count; i++) begin
          r.data = (op == OP_READ_ASC) ? shadow_vals[i] : shadow_vals[shadow_count-1-i];
          r.last = (i + 1 == shadow_count);
          expected_results.push_back(r);
        end
        if (shadow_count > max_read_len) max_read_len = shadow_count;
      end
      OP_REMOVE: begin
        kept = 0;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_vals[i] !== val) begin
            shadow_vals[kept] = shadow_vals[i];
            kept++;
          end
        end
        gone = shadow_count - kept;
        shadow_count = kept;
        if (gone == 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.removed = REMOVED_W'((gone > REMOVED_MAX) ? REMOVED_MAX : gone);
          if (gone > 1) multi_removes++;
        end
        expected_results.push_back(r);
      end
      default: begin
        shadow_count = 0;
        expected_results.push_back(r);
      end
    endcase
  endfunction

  // Offer one item, wait for it to be taken, then predict its results.
  // Called at a rising edge; valid stays high for the next item unless the
  // sender chooses to idle.
  task automatic send_item(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    // The ready seen at the falling edge holds until the next rising edge.
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (op <= OP_CLEAR) items_sent++;
    predict_results(op, val);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic signed [32:0] want,
                                      input logic signed [32:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each accepted result with the oldest expectation. Outputs and
  // ready are stable at the falling edge, so the item goes at the next rise.
  always @(negedge clk) begin : check_results
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result item: data %0d, removed %0d, status %0d, last %0d",
                 $time, data, removed_count, status, last);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("data", want.data, data);
        check_field("removed_count", want.removed, removed_count);
        check_field("status", want.status, status);
        check_field("last", want.last, last);
        results_checked++;
      end
    end
  end

  // Reads, remove and clear on an empty store, plus the ignored opcodes.
  task automatic test_empty_store();
    send_item(OP_READ_ASC, $urandom);
    send_item(OP_READ_DESC, $urandom);
    send_item(OP_UNUSED_FIRST, $urandom);
    send_item(OP_REMOVE, VAL_MIN);
    send_item(OP_CLEAR, $urandom);
    send_item(OP_UNUSED_LAST, $urandom);
    send_item(OP_UNUSED_MID, $urandom);
  endtask

  // Value extremes, duplicates, both read directions, remove hit and miss.
  task automatic test_ordering();
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, VAL_MAX);
    send_item(OP_INSERT, VAL_MIN);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, 1);
    send_item(OP_INSERT, VAL_MAX);
    send_item(OP_INSERT, VAL_MIN);
    send_item(OP_INSERT, 0);
    send_item(OP_READ_ASC, $urandom);
    send_item(OP_READ_DESC, $urandom);
    send_item(OP_REMOVE, 5);
    send_item(OP_REMOVE, VAL_MAX);
    send_item(OP_REMOVE, -1);
    send_item(OP_READ_ASC, 0);
    send_item(OP_CLEAR, VAL_MAX);
    send_item(OP_READ_DESC, VAL_MIN);
  endtask

  // Fill the store while the receiver holds off, then hit the full case and
  // remove a value held in every entry.
  task automatic test_full_store();
    hold_len <= 400;
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < CAPACITY; i++)
      send_item(OP_INSERT, (i % 2) ? $signed($urandom) : $signed($urandom_range(0, 6)) - 3);
    send_item(OP_INSERT, VAL_MIN);
    send_item(OP_READ_DESC, 0);
    send_item(OP_READ_ASC, 0);
    send_item(OP_CLEAR, 0);
    for (int i = 0; i < CAPACITY; i++) send_item(OP_INSERT, VAL_MIN);
    send_item(OP_INSERT, VAL_MAX);
    send_item(OP_REMOVE, VAL_MIN);
    send_item(OP_READ_ASC, 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $signed($urandom_range(0, 8)) - 4;
    if (sel < 6) begin
      case ($urandom_range(0, 5))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_MIN + 1;
        3: return VAL_MAX - 1;
        4: return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  // Random mix weighted towards inserts, with removes mostly of stored values.
  task automatic random_phase(input int unsigned n_items);
    int unsigned done;
    int unsigned sel;
    logic signed [DATA_W-1:0] val;
    done = 0;
    while (done < n_items) begin
      sel = $urandom_range(0, 99);
      val = pick_value();
      if (sel < 42) begin
        send_item(OP_INSERT, val);
      end else if (sel < 54) begin
        send_item(OP_READ_ASC, $urandom);
      end else if (sel < 66) begin
        send_item(OP_READ_DESC, $urandom);
      end else if (sel < 84) begin
        if (shadow_count != 0 && $urandom_range(0, 3) != 0)
          val = shadow_vals[$urandom_range(0, shadow_count - 1)];
        send_item(OP_REMOVE, val);
      end else if (sel < 88) begin
        send_item(OP_CLEAR, $urandom);
      end else begin
        send_item(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), $urandom);
        done--;
      end
      done++;
    end
  endtask

  task automatic test_random();
    set_idling(37, 74);
    random_phase(95);
    set_idling(74, 37);
    random_phase(95);
    set_idling(0, 0);
    random_phase(90);
  endtask

  // Main sequence.
  initial begin
    set_idling(37, 74);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_store();
    test_ordering();
    test_full_store();
    test_random();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4 * CAPACITY) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, expected_results.size());
      fail_count++;
    end
    $display("Run covered %0d items and %0d checked results, %0d full-store rejections,",
             items_sent, results_checked, full_rejects);
    $display("%0d removes of several copies and reads of up to %0d values.",
             multi_removes, max_read_len);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("%0t ns: timeout, %0d results still expected", $time, expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sle_pkg.sv
rtl/sorted_list_engine.sv
dv/tb_top.sv
